>>> design/sgcr_pkg.sv
// ----------------------------------------------------------------------------
// sgcr_pkg
// Shared types, sizes and helpers of the second gradient corner response block.
// ----------------------------------------------------------------------------
package sgcr_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);   // column position
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);  // row position
  localparam int unsigned WEFF_W = COL_W + 1;           // 1..MAX_WIDTH
  localparam int unsigned HEFF_W = ROW_W + 1;           // 1..MAX_HEIGHT

  localparam int unsigned FW_W       = 12;  // frame_width register
  localparam int unsigned FH_W       = 13;  // frame_height register
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned PIX_W  = 12;
  localparam int unsigned RESP_W = 30;
  localparam int unsigned SUM_W  = 16;  // signed 3-minus-3 sums

  localparam int unsigned RING_ROWS = 8;
  localparam int unsigned LANE_W    = $clog2(RING_ROWS);
  localparam int unsigned WIN       = 5;  // 5x5 intensity window
  localparam int unsigned GRID      = 3;  // 3x3 gradient grid

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  localparam logic [PIX_W-1:0] GRAD_MAX     = 12'd4080;
  localparam logic [FW_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [FH_W-1:0]  HEIGHT_RESET = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_e;

  typedef logic [PIX_W-1:0] pix_t;

  // position tags that travel with a result through the pipeline
  typedef struct packed {
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic             last;
    logic             left;
    logic             right;
    logic             top;
    logic             bottom;
  } pos_t;

  typedef struct packed {
    pix_t                     second_x;
    pix_t                     second_y;
    pix_t                     mixed_xy;
    logic signed [RESP_W-1:0] response_x25;
    logic [COL_W-1:0]         pixel_x;
    logic [ROW_W-1:0]         pixel_y;
    logic                     last;
  } result_t;

  // (a0+a1+a2) - (b0+b1+b2)
  function automatic logic signed [SUM_W-1:0] diff3(input pix_t a0, input pix_t a1,
                                                    input pix_t a2, input pix_t b0,
                                                    input pix_t b1, input pix_t b2);
    logic signed [SUM_W-1:0] pos;
    logic signed [SUM_W-1:0] neg;
    pos = $signed({4'b0000, a0}) + $signed({4'b0000, a1}) + $signed({4'b0000, a2});
    neg = $signed({4'b0000, b0}) + $signed({4'b0000, b1}) + $signed({4'b0000, b2});
    return pos - neg;
  endfunction

  function automatic pix_t clamp_grad(input logic signed [SUM_W-1:0] v);
    pix_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({4'b0000, GRAD_MAX})) begin
      r = GRAD_MAX;
    end else begin
      r = v[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/second_gradient_corner_response.sv
// ----------------------------------------------------------------------------
// second_gradient_corner_response
// 3x3 second-gradient corner response over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one request per clock (pixel or drain) and gives results in raster
// order, about two rows plus two pixels behind the input; drain requests
// release the rest at the end of a frame. A result is released by the request
// that completes its 5x5 neighborhood. Throughput is one request per clock,
// set by the single read of the line memory that each result needs; the
// input stalls only when the 8-entry result queue plus the results still in
// the 5-stage datapath are full. The line memory holds 8 rows x 2048 columns
// in 8 lanes of one word; it is not cleared after reset (no clearing pass),
// and only entries written in the current frame are ever used. A write to a
// frame size register restarts the frame.
module second_gradient_corner_response (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel / drain requests
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [sgcr_pkg::PIX_W-1:0]          intensity_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sgcr_pkg::PIX_W-1:0]          second_x_o,
  output logic [sgcr_pkg::PIX_W-1:0]          second_y_o,
  output logic [sgcr_pkg::PIX_W-1:0]          mixed_xy_o,
  output logic signed [sgcr_pkg::RESP_W-1:0]  response_x25_o,
  output logic [sgcr_pkg::COL_W-1:0]          pixel_x_o,
  output logic [sgcr_pkg::ROW_W-1:0]          pixel_y_o,
  output logic                                last_of_frame_o,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sgcr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sgcr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned COL_W  = sgcr_pkg::COL_W;
  localparam int unsigned ROW_W  = sgcr_pkg::ROW_W;
  localparam int unsigned WEFF_W = sgcr_pkg::WEFF_W;
  localparam int unsigned HEFF_W = sgcr_pkg::HEFF_W;
  localparam int unsigned PIX_W  = sgcr_pkg::PIX_W;
  localparam int unsigned LANE_W = sgcr_pkg::LANE_W;
  localparam int unsigned RING   = sgcr_pkg::RING_ROWS;
  localparam int unsigned WIN    = sgcr_pkg::WIN;
  localparam int unsigned GRID   = sgcr_pkg::GRID;
  localparam int unsigned RESP_W = sgcr_pkg::RESP_W;
  localparam int unsigned FDEPTH = sgcr_pkg::FIFO_DEPTH;
  localparam int unsigned FAW    = sgcr_pkg::FIFO_AW;
  localparam int unsigned FCW    = sgcr_pkg::FIFO_CW;

  // --------------------------------------------------------------------------
  // Frame registers and effective size
  // --------------------------------------------------------------------------
  logic [sgcr_pkg::FW_W-1:0] width_q, width_d;
  logic [sgcr_pkg::FH_W-1:0] height_q, height_d;
  logic [WEFF_W-1:0]         w_eff, wm1;
  logic [HEFF_W-1:0]         h_eff, hm1;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WEFF_W'(1);
    end else if (width_q > sgcr_pkg::FW_W'(sgcr_pkg::MAX_WIDTH)) begin
      w_eff = WEFF_W'(sgcr_pkg::MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HEFF_W'(1);
    end else if (height_q > sgcr_pkg::FH_W'(sgcr_pkg::MAX_HEIGHT)) begin
      h_eff = HEFF_W'(sgcr_pkg::MAX_HEIGHT);
    end else begin
      h_eff = HEFF_W'(height_q);
    end
    wm1 = w_eff - WEFF_W'(1);
    hm1 = h_eff - HEFF_W'(1);
  end

  // --------------------------------------------------------------------------
  // Raster control: input / output positions and release decision
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic             in_done_q, in_done_d, out_done_q, out_done_d;

  logic             in_acc, cfg_acc, cfg_hit;
  logic             mem_we, emit;
  logic [COL_W-1:0] wr_col;
  logic [LANE_W-1:0] wr_lane;
  logic [COL_W:0]   col_inc, ocol_inc, nx_full;
  logic [ROW_W:0]   row_inc, ny_full;
  logic             res_ready;
  logic [COL_W-1:0] rd_addr;
  sgcr_pkg::pos_t   em_pos;

  assign in_acc      = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    in_done_d  = in_done_q;
    out_done_d = out_done_q;
    width_d    = width_q;
    height_d   = height_q;
    cfg_hit    = 1'b0;
    mem_we     = 1'b0;
    emit       = 1'b0;
    wr_col     = in_col_q;
    wr_lane    = in_row_q[LANE_W-1:0];
    col_inc    = '0;
    row_inc    = '0;
    ocol_inc   = '0;
    nx_full    = '0;
    ny_full    = '0;
    res_ready  = 1'b0;
    rd_addr    = '0;
    em_pos     = '0;

    if (in_acc) begin
      if (req_type_i == sgcr_pkg::REQ_PIXEL) begin
        // new frame after a complete one (or position off the frame)
        if (in_done_q || ({1'b0, in_col_q} >= w_eff) || ({1'b0, in_row_q} >= h_eff)) begin
          in_col_d   = '0;
          in_row_d   = '0;
          out_col_d  = '0;
          out_row_d  = '0;
          in_done_d  = 1'b0;
          out_done_d = 1'b0;
        end
        mem_we  = 1'b1;
        wr_col  = in_col_d;
        wr_lane = in_row_d[LANE_W-1:0];
        col_inc = {1'b0, in_col_d} + (COL_W+1)'(1);
        if (col_inc >= w_eff) begin
          in_col_d = '0;
          row_inc  = {1'b0, in_row_d} + (ROW_W+1)'(1);
          if (row_inc >= h_eff) begin
            in_row_d  = '0;
            in_done_d = 1'b1;
          end else begin
            in_row_d = row_inc[ROW_W-1:0];
          end
        end else begin
          in_col_d = col_inc[COL_W-1:0];
        end
      end

      // result (ox,oy) is ready once pixel (min(ox+2,W-1), min(oy+2,H-1)) is in
      nx_full = {1'b0, out_col_d} + (COL_W+1)'(2);
      if (nx_full > wm1) nx_full = wm1;
      ny_full = {1'b0, out_row_d} + (ROW_W+1)'(2);
      if (ny_full > hm1) ny_full = hm1;
      res_ready = !out_done_d &&
                  (in_done_d || ({1'b0, in_row_d} > ny_full) ||
                   (({1'b0, in_row_d} == ny_full) && ({1'b0, in_col_d} > nx_full)));

      if (res_ready) begin
        emit          = 1'b1;
        rd_addr       = nx_full[COL_W-1:0];
        em_pos.x      = out_col_d;
        em_pos.y      = out_row_d;
        em_pos.left   = (out_col_d == '0);
        em_pos.right  = ({1'b0, out_col_d} == wm1);
        em_pos.top    = (out_row_d == '0);
        em_pos.bottom = ({1'b0, out_row_d} == hm1);
        em_pos.last   = em_pos.right & em_pos.bottom;
        ocol_inc      = {1'b0, out_col_d} + (COL_W+1)'(1);
        if (em_pos.last) begin
          out_done_d = 1'b1;
          out_col_d  = '0;
          out_row_d  = '0;
        end else if (ocol_inc >= w_eff) begin
          out_col_d = '0;
          out_row_d = out_row_d + ROW_W'(1);
        end else begin
          out_col_d = ocol_inc[COL_W-1:0];
        end
      end
    end

    // register write: new size and frame restart
    if (cfg_acc) begin
      unique case (cfg_index_i)
        sgcr_pkg::REG_FRAME_WIDTH: begin
          width_d = cfg_data_i[sgcr_pkg::FW_W-1:0];
          cfg_hit = 1'b1;
        end
        sgcr_pkg::REG_FRAME_HEIGHT: begin
          height_d = cfg_data_i[sgcr_pkg::FH_W-1:0];
          cfg_hit  = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
      if (cfg_hit) begin
        in_col_d   = '0;
        in_row_d   = '0;
        out_col_d  = '0;
        out_row_d  = '0;
        in_done_d  = 1'b0;
        out_done_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= sgcr_pkg::WIDTH_RESET;
      height_q   <= sgcr_pkg::HEIGHT_RESET;
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      in_done_q  <= 1'b0;
      out_done_q <= 1'b0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      in_done_q  <= in_done_d;
      out_done_q <= out_done_d;
    end
  end

  // --------------------------------------------------------------------------
  // Line memory: one word per column, one lane per ring row.
  // Read returns old data; a same-cycle write is forwarded next cycle.
  // --------------------------------------------------------------------------
  logic [RING-1:0][PIX_W-1:0] line_mem [sgcr_pkg::MAX_WIDTH];
  logic [RING-1:0][PIX_W-1:0] rd_data_q;
  // columns 0 and 1 of each ring row, for the left border window load
  logic [RING-1:0][PIX_W-1:0] edge0_q, edge1_q;
  logic                       fwd_vld_q;
  logic [COL_W-1:0]           fwd_col_q;
  logic [LANE_W-1:0]          fwd_lane_q;
  sgcr_pkg::pix_t             fwd_pix_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[wr_col][wr_lane] <= intensity_i;
    end
    if (emit) begin
      rd_data_q <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && (wr_col == COL_W'(0))) edge0_q[wr_lane] <= intensity_i;
    if (mem_we && (wr_col == COL_W'(1))) edge1_q[wr_lane] <= intensity_i;
    fwd_col_q  <= wr_col;
    fwd_lane_q <= wr_lane;
    fwd_pix_q  <= intensity_i;
  end

  // --------------------------------------------------------------------------
  // Datapath stages (never stall; the result queue absorbs back pressure)
  //   rd  : memory word back       win : 5x5 window
  //   grd : 3x3 first gradients    snd : second gradients
  //   prd : products               -> response into the queue
  // --------------------------------------------------------------------------
  logic           rd_vld_q, win_vld_q, grd_vld_q, snd_vld_q, prd_vld_q;
  sgcr_pkg::pos_t rd_pos_q, win_pos_q, grd_pos_q, snd_pos_q, prd_pos_q;
  logic [COL_W-1:0] rd_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      win_vld_q <= 1'b0;
      grd_vld_q <= 1'b0;
      snd_vld_q <= 1'b0;
      prd_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= mem_we;
      rd_vld_q  <= emit;
      win_vld_q <= rd_vld_q;
      grd_vld_q <= win_vld_q;
      snd_vld_q <= grd_vld_q;
      prd_vld_q <= snd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q  <= em_pos;
    rd_addr_q <= rd_addr;
    win_pos_q <= rd_pos_q;
    grd_pos_q <= win_pos_q;
    snd_pos_q <= grd_pos_q;
    prd_pos_q <= snd_pos_q;
  end

  // ---- window load / shift ----
  logic [RING-1:0][PIX_W-1:0]           col_fix;
  logic [WIN-1:0][LANE_W-1:0]           row_lane;
  logic signed [ROW_W+1:0]              ry;
  logic [WIN-1:0][WIN-1:0][PIX_W-1:0]   win_q, win_d;

  always_comb begin
    col_fix = rd_data_q;
    if (fwd_vld_q && (fwd_col_q == rd_addr_q)) begin
      col_fix[fwd_lane_q] = fwd_pix_q;
    end
    ry = '0;
    // window rows oy-2..oy+2, clamped to the frame
    for (int k = 0; k < WIN; k++) begin
      ry = $signed({2'b00, rd_pos_q.y}) - (ROW_W+2)'(2) + (ROW_W+2)'(k);
      if (ry < 0) begin
        ry = '0;
      end else if (ry > $signed({1'b0, hm1})) begin
        ry = $signed({1'b0, hm1});
      end
      row_lane[k] = ry[LANE_W-1:0];
    end
    win_d = win_q;
    for (int k = 0; k < WIN; k++) begin
      if (rd_pos_q.left) begin
        // columns -2..2 clamp to 0,0,0,min(1,W-1),min(2,W-1)
        win_d[k][0] = edge0_q[row_lane[k]];
        win_d[k][1] = edge0_q[row_lane[k]];
        win_d[k][2] = edge0_q[row_lane[k]];
        win_d[k][3] = (w_eff > WEFF_W'(1)) ? edge1_q[row_lane[k]] : edge0_q[row_lane[k]];
      end else begin
        for (int j = 0; j < WIN - 1; j++) begin
          win_d[k][j] = win_q[k][j+1];
        end
      end
      win_d[k][WIN-1] = col_fix[row_lane[k]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) win_q <= win_d;
  end

  // ---- first stage: 3x3 gradients around the center ----
  logic [GRID-1:0][GRID-1:0][PIX_W-1:0] grd_h_q, grd_v_q, grd_h_d, grd_v_d;

  always_comb begin
    for (int r = 0; r < GRID; r++) begin
      for (int c = 0; c < GRID; c++) begin
        grd_h_d[r][c] = sgcr_pkg::clamp_grad(sgcr_pkg::diff3(
            win_q[r][c], win_q[r+1][c], win_q[r+2][c],
            win_q[r][c+2], win_q[r+1][c+2], win_q[r+2][c+2]));
        grd_v_d[r][c] = sgcr_pkg::clamp_grad(sgcr_pkg::diff3(
            win_q[r][c], win_q[r][c+1], win_q[r][c+2],
            win_q[r+2][c], win_q[r+2][c+1], win_q[r+2][c+2]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grd_h_q <= grd_h_d;
    grd_v_q <= grd_v_d;
  end

  // ---- second stage: gradients off the frame take the border gradient ----
  logic [GRID-1:0][GRID-1:0][PIX_W-1:0] hg, vg;
  sgcr_pkg::pix_t snd_x_q, snd_y_q, snd_m_q;
  sgcr_pkg::pix_t snd_x_d, snd_y_d, snd_m_d;
  int unsigned    rs, cs;

  always_comb begin
    for (int r = 0; r < GRID; r++) begin
      for (int c = 0; c < GRID; c++) begin
        rs = r;
        cs = c;
        if (r == 0 && grd_pos_q.top) rs = 1;
        if (r == GRID - 1 && grd_pos_q.bottom) rs = 1;
        if (c == 0 && grd_pos_q.left) cs = 1;
        if (c == GRID - 1 && grd_pos_q.right) cs = 1;
        hg[r][c] = grd_h_q[rs][cs];
        vg[r][c] = grd_v_q[rs][cs];
      end
    end
    snd_x_d = sgcr_pkg::clamp_grad(sgcr_pkg::diff3(hg[0][0], hg[1][0], hg[2][0],
                                                   hg[0][2], hg[1][2], hg[2][2]));
    snd_y_d = sgcr_pkg::clamp_grad(sgcr_pkg::diff3(vg[0][0], vg[0][1], vg[0][2],
                                                   vg[2][0], vg[2][1], vg[2][2]));
    snd_m_d = sgcr_pkg::clamp_grad(sgcr_pkg::diff3(hg[0][0], hg[0][1], hg[0][2],
                                                   hg[2][0], hg[2][1], hg[2][2]));
  end

  always_ff @(posedge clk_i) begin
    snd_x_q <= snd_x_d;
    snd_y_q <= snd_y_d;
    snd_m_q <= snd_m_d;
  end

  // ---- products ----
  logic [2*PIX_W-1:0]     prd_xy_q, prd_mm_q;
  logic [2*PIX_W+1:0]     prd_ss_q;
  logic [PIX_W:0]         sum_xy;
  sgcr_pkg::pix_t         prd_x_q, prd_y_q, prd_m_q;

  assign sum_xy = {1'b0, snd_x_q} + {1'b0, snd_y_q};

  always_ff @(posedge clk_i) begin
    prd_xy_q <= snd_x_q * snd_y_q;
    prd_mm_q <= snd_m_q * snd_m_q;
    prd_ss_q <= sum_xy * sum_xy;
    prd_x_q  <= snd_x_q;
    prd_y_q  <= snd_y_q;
    prd_m_q  <= snd_m_q;
  end

  // ---- response: 25*(sx*sy - mxy^2) - (sx+sy)^2, 25*d as 16d + 8d + d ----
  logic signed [2*PIX_W:0]  det;
  logic signed [31:0]       det_ext, resp_full;
  sgcr_pkg::result_t        res_new;

  always_comb begin
    det       = $signed({1'b0, prd_xy_q}) - $signed({1'b0, prd_mm_q});
    det_ext   = 32'(det);
    resp_full = (det_ext <<< 4) + (det_ext <<< 3) + det_ext - $signed({6'b0, prd_ss_q});
    res_new.second_x     = prd_x_q;
    res_new.second_y     = prd_y_q;
    res_new.mixed_xy     = prd_m_q;
    res_new.response_x25 = resp_full[RESP_W-1:0];
    res_new.pixel_x      = prd_pos_q.x;
    res_new.pixel_y      = prd_pos_q.y;
    res_new.last         = prd_pos_q.last;
  end

  // --------------------------------------------------------------------------
  // Result queue; input is held off while queue plus in-flight could overflow
  // --------------------------------------------------------------------------
  sgcr_pkg::result_t fifo_q [FDEPTH];
  logic [FAW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [FCW-1:0]    cnt_q, cnt_d;
  logic              push, pop;
  logic [FCW:0]      occupied;
  sgcr_pkg::result_t head;

  assign push     = prd_vld_q;
  assign pop      = out_valid_o & out_ready_i;
  assign occupied = {1'b0, cnt_q} + (FCW+1)'($countones(
                      {rd_vld_q, win_vld_q, grd_vld_q, snd_vld_q, prd_vld_q}));
  assign in_ready_o = (occupied < (FCW+1)'(FDEPTH));

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + FCW'(1);
    if (pop && !push) cnt_d = cnt_q - FCW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + FAW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + FAW'(1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= res_new;
  end

  assign head            = fifo_q[rd_ptr_q];
  assign out_valid_o     = (cnt_q != '0);
  assign second_x_o      = head.second_x;
  assign second_y_o      = head.second_y;
  assign mixed_xy_o      = head.mixed_xy;
  assign response_x25_o  = head.response_x25;
  assign pixel_x_o       = head.pixel_x;
  assign pixel_y_o       = head.pixel_y;
  assign last_of_frame_o = head.last;

endmodule

>>> design/sgcr_checker.sv
// ----------------------------------------------------------------------------
// sgcr_checker
// Port-level checks of the second gradient corner response block.
// ----------------------------------------------------------------------------
module sgcr_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic [sgcr_pkg::PIX_W-1:0]          second_x_o,
  input  logic [sgcr_pkg::PIX_W-1:0]          second_y_o,
  input  logic [sgcr_pkg::PIX_W-1:0]          mixed_xy_o,
  input  logic signed [sgcr_pkg::RESP_W-1:0]  response_x25_o,
  input  logic [sgcr_pkg::COL_W-1:0]          pixel_x_o,
  input  logic [sgcr_pkg::ROW_W-1:0]          pixel_y_o
);

  logic                          seen_q;
  logic [sgcr_pkg::COL_W-1:0]    px_q;
  logic [sgcr_pkg::ROW_W-1:0]    py_q;
  logic                          out_acc;
  logic signed [31:0]            sx, sy, mm, expect_r;

  assign out_acc = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      px_q   <= '0;
      py_q   <= '0;
    end else if (out_acc) begin
      seen_q <= 1'b1;
      px_q   <= pixel_x_o;
      py_q   <= pixel_y_o;
    end
  end

  always_comb begin
    sx       = $signed({20'b0, second_x_o});
    sy       = $signed({20'b0, second_y_o});
    mm       = $signed({20'b0, mixed_xy_o});
    expect_r = 32'sd25 * (sx * sy - mm * mm) - (sx + sy) * (sx + sy);
  end

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(response_x25_o)
      && $stable(pixel_x_o) && $stable(pixel_y_o))
    else $error("result changed while stalled");

  // response agrees with the three gradient fields
  a_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> response_x25_o == expect_r[sgcr_pkg::RESP_W-1:0])
    else $error("response does not match gradients");

  // gradients stay within the clamp range
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> second_x_o <= sgcr_pkg::GRAD_MAX && second_y_o <= sgcr_pkg::GRAD_MAX
      && mixed_xy_o <= sgcr_pkg::GRAD_MAX)
    else $error("gradient above clamp");

  // results advance in raster order (or restart at the frame origin)
  a_raster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |->
      (pixel_x_o == px_q + 1'b1 && pixel_y_o == py_q) ||
      (pixel_x_o == '0 && pixel_y_o == py_q + 1'b1) ||
      (pixel_x_o == '0 && pixel_y_o == '0))
    else $error("result out of raster order");

endmodule

bind second_gradient_corner_response sgcr_checker u_sgcr_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the second gradient corner response block.
// ----------------------------------------------------------------------------
// Frames of pixel requests are streamed through the block. Most of them are
// followed by drain requests that flush the results still held back. A
// behavioral line-ring predictor in this file computes every expected result
// when its request is accepted. A monitor compares each result taken from the
// block, field by field, with the oldest prediction. The run walks through
// directed border and register cases, then random frames under several
// idle/stall mixes, a long output hold-off and a full pause of the input.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned PIX_W      = sgcr_pkg::PIX_W;
  localparam int unsigned RESP_W     = sgcr_pkg::RESP_W;
  localparam int unsigned COL_W      = sgcr_pkg::COL_W;
  localparam int unsigned ROW_W      = sgcr_pkg::ROW_W;
  localparam int unsigned FW_W       = sgcr_pkg::FW_W;
  localparam int unsigned FH_W       = sgcr_pkg::FH_W;
  localparam int unsigned CFG_IDX_W  = sgcr_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = sgcr_pkg::CFG_DATA_W;
  localparam int unsigned RING_ROWS  = sgcr_pkg::RING_ROWS;
  localparam int unsigned MAX_WIDTH  = sgcr_pkg::MAX_WIDTH;
  localparam int unsigned MAX_HEIGHT = sgcr_pkg::MAX_HEIGHT;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 16;  // datapath depth plus margin
  localparam int PHASE_PIXELS   = 80;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  req_type_i = sgcr_pkg::REQ_PIXEL;
  logic [PIX_W-1:0]      intensity_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PIX_W-1:0]      second_x_o, second_y_o, mixed_xy_o;
  logic signed [RESP_W-1:0] response_x25_o;
  logic [COL_W-1:0]      pixel_x_o;
  logic [ROW_W-1:0]      pixel_y_o;
  logic                  last_of_frame_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  second_gradient_corner_response dut (.*);

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: an 8-row intensity ring and the raster positions.
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] line_ring [RING_ROWS][MAX_WIDTH];
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;
  int               in_col, in_row, out_col, out_row;
  bit               frame_in_done, frame_out_done;
  sgcr_pkg::result_t corner_q [$];

  int  mismatches = 0;
  int  send_gap_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 0;
  int  hold_left = 0;
  int  idle_count = 0;
  int  pixels_sent = 0;

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int active_width();
    return clampi(int'(width_reg), 1, MAX_WIDTH);
  endfunction

  function automatic int active_height();
    return clampi(int'(height_reg), 1, MAX_HEIGHT);
  endfunction

  function automatic int ring_pixel(int x, int y);
    int cx, cy;
    cx = clampi(x, 0, active_width() - 1);
    cy = clampi(y, 0, active_height() - 1);
    return int'(line_ring[cy % RING_ROWS][cx]);
  endfunction

  // first-stage gradients at a border-replicated position, clamped
  task automatic gradients_at(input int x, input int y, output int hor, output int ver);
    int cx, cy, p;
    cx = clampi(x, 0, active_width() - 1);
    cy = clampi(y, 0, active_height() - 1);
    hor = 0;
    ver = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        p = ring_pixel(cx + dx, cy + dy);
        hor += dx < 0 ? p : (dx > 0 ? -p : 0);
        ver += dy < 0 ? p : (dy > 0 ? -p : 0);
      end
    end
    hor = clampi(hor, 0, int'(sgcr_pkg::GRAD_MAX));
    ver = clampi(ver, 0, int'(sgcr_pkg::GRAD_MAX));
  endtask

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    frame_in_done = 0;
    frame_out_done = 0;
  endfunction

  function automatic bit corner_ready();
    longint got, need, nx, ny, w, h;
    w = active_width();
    h = active_height();
    if (frame_out_done) return 0;
    got = frame_in_done ? w * h : longint'(in_row) * w + in_col;
    nx = out_col + 2 > w - 1 ? w - 1 : out_col + 2;
    ny = out_row + 2 > h - 1 ? h - 1 : out_row + 2;
    need = ny * w + nx;
    return got > need;
  endfunction

  task automatic emit_corner();
    sgcr_pkg::result_t r;
    int sx, sy, mxy, hg, vg, w, h;
    longint resp;
    w = active_width();
    h = active_height();
    sx = 0;
    sy = 0;
    mxy = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        gradients_at(out_col + dx, out_row + dy, hg, vg);
        sx  += dx < 0 ? hg : (dx > 0 ? -hg : 0);
        sy  += dy < 0 ? vg : (dy > 0 ? -vg : 0);
        mxy += dy < 0 ? hg : (dy > 0 ? -hg : 0);
      end
    end
    sx = clampi(sx, 0, int'(sgcr_pkg::GRAD_MAX));
    sy = clampi(sy, 0, int'(sgcr_pkg::GRAD_MAX));
    mxy = clampi(mxy, 0, int'(sgcr_pkg::GRAD_MAX));
    resp = 25 * (longint'(sx) * sy - longint'(mxy) * mxy) - longint'(sx + sy) * (sx + sy);
    r.second_x     = PIX_W'(sx);
    r.second_y     = PIX_W'(sy);
    r.mixed_xy     = PIX_W'(mxy);
    r.response_x25 = resp[RESP_W-1:0];
    r.pixel_x      = COL_W'(out_col);
    r.pixel_y      = ROW_W'(out_row);
    r.last         = (out_col == w - 1) && (out_row == h - 1);
    corner_q = {corner_q, r};
    if (r.last) begin
      frame_out_done = 1;
      out_col = 0;
      out_row = 0;
    end else if (++out_col >= w) begin
      out_col = 0;
      out_row++;
    end
  endtask

  // one accepted request: store the pixel, then release the next ready result
  task automatic predict_request(input sgcr_pkg::req_e kind, input sgcr_pkg::pix_t value);
    int w, h;
    if (kind == sgcr_pkg::REQ_PIXEL) begin
      w = active_width();
      h = active_height();
      if (frame_in_done || in_col >= w || in_row >= h) restart_frame();
      line_ring[in_row % RING_ROWS][in_col] = value;
      if (++in_col >= w) begin
        in_col = 0;
        if (++in_row >= h) begin
          in_row = 0;
          frame_in_done = 1;
        end
      end
    end
    if (corner_ready()) emit_corner();
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, an optional long hold-off, and the checker.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    sgcr_pkg::result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (corner_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result at x=%0d y=%0d", pixel_x_o, pixel_y_o);
      end else begin
        e = corner_q.pop_front();
        if (second_x_o !== e.second_x || second_y_o !== e.second_y ||
            mixed_xy_o !== e.mixed_xy || response_x25_o !== e.response_x25 ||
            pixel_x_o !== e.pixel_x || pixel_y_o !== e.pixel_y ||
            last_of_frame_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"bad result: exp sx=%0d sy=%0d mxy=%0d r=%0d x=%0d y=%0d last=%0b",
                      " / got sx=%0d sy=%0d mxy=%0d r=%0d x=%0d y=%0d last=%0b"},
                     e.second_x, e.second_y, e.mixed_xy, e.response_x25, e.pixel_x,
                     e.pixel_y, e.last, second_x_o, second_y_o, mixed_xy_o,
                     response_x25_o, pixel_x_o, pixel_y_o, last_of_frame_o);
        end
      end
    end
  end

  // watchdog: cycles in which no channel moves anything
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("second_gradient_corner_response: mismatch");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Valid stays high from one request to the next when no gap is taken.
  task automatic send_request(input sgcr_pkg::req_e kind, input sgcr_pkg::pix_t value);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= kind;
    intensity_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(kind, value);
    if (kind == sgcr_pkg::REQ_PIXEL) pixels_sent++;
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (corner_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_results_done();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == sgcr_pkg::REG_FRAME_WIDTH) begin
      width_reg = data[FW_W-1:0];
      restart_frame();
    end else if (idx == sgcr_pkg::REG_FRAME_HEIGHT) begin
      height_reg = data[FH_W-1:0];
      restart_frame();
    end
  endtask

  task automatic set_frame(input int w, input int h);
    write_reg(sgcr_pkg::REG_FRAME_WIDTH, {1'($urandom_range(1)), 12'(w)});
    write_reg(sgcr_pkg::REG_FRAME_HEIGHT, 13'(h));
  endtask

  function automatic sgcr_pkg::pix_t pick_pixel(input int style);
    case (style)
      0: return sgcr_pkg::pix_t'($urandom_range(4095));
      1: return sgcr_pkg::pix_t'($urandom_range(200));     // mostly unclamped sums
      2: return $urandom_range(1) ? sgcr_pkg::pix_t'(4095) : sgcr_pkg::pix_t'(0);
      default: return sgcr_pkg::pix_t'(1000 + $urandom_range(300));
    endcase
  endfunction

  // pixels of one frame, optionally cut short, then, if asked, drains until flushed
  task automatic stream_frame(input int count, input int style, input bit drain,
                              input int noise_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < noise_pct)
        send_request(sgcr_pkg::REQ_DRAIN, sgcr_pkg::pix_t'($urandom));
      send_request(sgcr_pkg::REQ_PIXEL, pick_pixel(style));
    end
    if (drain) begin
      while (!frame_out_done && frame_in_done)
        send_request(sgcr_pkg::REQ_DRAIN, sgcr_pkg::pix_t'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    set_frame(4, 3);
    send_request(sgcr_pkg::REQ_DRAIN, '0);             // nothing ready yet
    send_request(sgcr_pkg::REQ_PIXEL, 12'd0);
    send_request(sgcr_pkg::REQ_PIXEL, 12'd4095);
    send_request(sgcr_pkg::REQ_PIXEL, 12'hAAA);
    send_request(sgcr_pkg::REQ_PIXEL, 12'h555);
    send_request(sgcr_pkg::REQ_PIXEL, 12'd4095);
    send_request(sgcr_pkg::REQ_PIXEL, 12'd0);
    send_request(sgcr_pkg::REQ_PIXEL, 12'd4095);
    send_request(sgcr_pkg::REQ_PIXEL, 12'd0);
    send_request(sgcr_pkg::REQ_PIXEL, 12'd16);
    send_request(sgcr_pkg::REQ_PIXEL, 12'd4080);
    send_request(sgcr_pkg::REQ_PIXEL, 12'd1);
    send_request(sgcr_pkg::REQ_PIXEL, 12'd2048);
    while (!frame_out_done) send_request(sgcr_pkg::REQ_DRAIN, '0);
    send_request(sgcr_pkg::REQ_DRAIN, '0);             // frame already flushed
    // full frame left undrained, then a new pixel drops the leftovers
    stream_frame(12, 0, 0, 0);
    stream_frame(12, 2, 1, 0);
    // zero width and height act as 1x1
    write_reg(sgcr_pkg::REG_FRAME_WIDTH, '0);
    write_reg(sgcr_pkg::REG_FRAME_HEIGHT, '0);
    stream_frame(3, 0, 1, 0);
    // unknown indexes change nothing
    write_reg(CFG_IDX_W'(2), 13'h1FFF);
    write_reg(CFG_IDX_W'(3), 13'h0AAA);
    stream_frame(2, 0, 1, 0);
  endtask

  task automatic test_register_extremes();
    write_reg(sgcr_pkg::REG_FRAME_WIDTH, 13'h0FFF);    // saturates to full width
    write_reg(sgcr_pkg::REG_FRAME_HEIGHT, 13'd1);
    stream_frame(20, 0, 0, 0);
    write_reg(sgcr_pkg::REG_FRAME_WIDTH, 13'd1);
    write_reg(sgcr_pkg::REG_FRAME_HEIGHT, 13'h1FFF);   // saturates to full height
    stream_frame(20, 3, 0, 0);
    write_reg(sgcr_pkg::REG_FRAME_HEIGHT, 13'd1);
    write_reg(sgcr_pkg::REG_FRAME_WIDTH, 13'd2);
    stream_frame(2, 0, 1, 0);
  endtask

  task automatic test_random_frames(input int gap_pct, input int stall);
    int w, h, target;
    send_gap_pct = gap_pct;
    stall_pct = stall;
    target = pixels_sent + PHASE_PIXELS;
    while (pixels_sent < target) begin
      w = ($urandom_range(15) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 9);
      if ($urandom_range(3) == 0) write_reg(CFG_IDX_W'($urandom_range(2, 3)), 13'($urandom));
      if ($urandom_range(3) != 0 || active_width() != w || active_height() != h)
        set_frame(w, h);
      case ($urandom_range(9))
        0: stream_frame($urandom_range(1, w * h), $urandom_range(3), 0, 5);  // cut short
        1: stream_frame(w * h, $urandom_range(3), 0, 5);                    // left undrained
        default: stream_frame(w * h, $urandom_range(3), 1, 5);
      endcase
    end
    wait_results_done();
  endtask

  task automatic test_output_hold();
    send_gap_pct = 0;
    stall_pct = 0;
    set_frame(12, 10);
    hold_req = 1;
    stream_frame(120, 0, 1, 0);
    wait_results_done();
  endtask

  task automatic test_input_pause();
    send_gap_pct = 20;
    stall_pct = 30;
    set_frame(9, 8);
    stream_frame(40, 1, 0, 0);
    wait_results_done();                               // every result so far is out
    stream_frame(32, 1, 1, 0);
    wait_results_done();
  endtask

  initial begin
    width_reg = sgcr_pkg::WIDTH_RESET;
    height_reg = sgcr_pkg::HEIGHT_RESET;
    restart_frame();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_register_extremes();
    test_random_frames(0, 0);
    test_random_frames(56, 0);
    test_random_frames(0, 56);
    test_random_frames(16, 16);
    test_output_hold();
    test_input_pause();
    wait_results_done();
    if (mismatches == 0) begin
      $display("second_gradient_corner_response: match");
    end else begin
      $display("second_gradient_corner_response: mismatch");
    end
    $finish;
  end

endmodule
